// File: rtl/sst_pkg.sv
package sst_pkg;

    // Item kinds on the slave side (tuser)
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Frame end status
    localparam logic [1:0] STATUS_NONE   = 2'd0;
    localparam logic [1:0] STATUS_ACCEPT = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_LOW_THRESHOLD    = 2'd0;
    localparam cfg_index_t REG_HYSTERESIS       = 2'd1;
    localparam cfg_index_t REG_CONTROL_INTERVAL = 2'd2;
    localparam cfg_index_t REG_LOG_INTERVAL     = 2'd3;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [11:0] LOW_THRESHOLD_RST    = 12'd288;
    localparam logic [11:0] HYSTERESIS_RST       = 12'd16;
    localparam logic [15:0] CONTROL_INTERVAL_RST = 16'd30;
    localparam logic [15:0] LOG_INTERVAL_RST     = 16'd10;

    // Scratchpad layout
    localparam logic [3:0] FRAME_BYTES  = 4'd9;
    localparam logic [3:0] COUNT_MAX    = 4'd15;
    localparam logic [3:0] POS_RAW_LOW  = 4'd0;
    localparam logic [3:0] POS_RAW_HIGH = 4'd1;
    localparam logic [3:0] POS_CONFIG   = 4'd4;

    // Resolution codes from config byte bits 6..5
    localparam logic [1:0] RES_9BIT  = 2'd0;
    localparam logic [1:0] RES_10BIT = 2'd1;
    localparam logic [1:0] RES_11BIT = 2'd2;
    localparam logic [1:0] RES_12BIT = 2'd3;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic [1:0]  pad;
        logic        log_due;
        logic        control_done;
        logic [1:0]  reading_status;
        logic [15:0] temperature;
        logic        overshoot_alert;
        logic        heat_on;
    } result_t;

    // One byte of the reflected 1-Wire CRC-8
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ b[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [15:0] res_mask(input logic [1:0] res);
        logic [15:0] m;
        unique case (res)
            RES_9BIT:  m = 16'hFFF8;
            RES_10BIT: m = 16'hFFFC;
            RES_11BIT: m = 16'hFFFE;
            RES_12BIT: m = 16'hFFFF;
            default:   m = 16'hFFFF;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/sensor_scratchpad_thermostat_unit.sv
// Hysteresis thermostat fed by 1-Wire thermometer scratchpad reads. Each slave item is either a
// scratchpad byte (s_tuser = 0, byte in s_tdata, s_tlast on the final byte of a read) or a
// one-second tick (s_tuser = 1). Bytes run through the 1-Wire CRC-8; a read of exactly nine
// bytes whose CRC leaves zero stores bytes 0/1 as the temperature in 1/16 degree, with low bits
// cleared per the resolution field of byte 4. Ticks advance saturating control and log
// counters; a control decision (only once a reading has been stored) turns the heater on below
// low_threshold and off at or above low_threshold + hysteresis, and raises the overshoot alert
// above that sum. Every item yields exactly one result item. Throughput is one item per clock
// while m_tready does not stall the result register; an item passes the input register, then the
// result register, with one pass of CRC step / compare logic between them. Configuration writes
// are always accepted and must only be made while the block is idle.
module sensor_scratchpad_thermostat_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sst_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,   // frame_last
    input  logic                            s_tuser,   // op
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sst_pkg::OUT_TDATA_W-1:0] m_tdata,   // [0] heat_on, [1] overshoot_alert,
                                                       // [17:2] temperature, [19:18]
                                                       // reading_status, [20] control_done,
                                                       // [21] log_due, [23:22] zero
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  sst_pkg::cfg_index_t             cfg_index,
    input  logic [sst_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sst_pkg::*;

    // configuration
    logic [11:0] low_threshold_reg;
    logic [11:0] hysteresis_reg;
    logic [15:0] control_interval_reg;
    logic [15:0] log_interval_reg;

    // input register
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // block state
    logic [7:0]  crc_reg,         crc_next;
    logic [3:0]  byte_count_reg,  byte_count_next;
    logic [7:0]  raw_low_reg,     raw_low_next;
    logic [7:0]  raw_high_reg,    raw_high_next;
    logic [1:0]  res_reg,         res_next;
    logic [15:0] temp_reg,        temp_next;
    logic        reading_valid_reg, reading_valid_next;
    logic        heater_state_reg,  heater_state_next;
    logic        alert_state_reg,   alert_state_next;
    logic [15:0] ctrl_elapsed_reg,  ctrl_elapsed_next;
    logic [15:0] log_elapsed_reg,   log_elapsed_next;

    // result register
    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic advance;

    // The input stage moves on whenever the result register is free or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_threshold_reg    <= LOW_THRESHOLD_RST;
            hysteresis_reg       <= HYSTERESIS_RST;
            control_interval_reg <= CONTROL_INTERVAL_RST;
            log_interval_reg     <= LOG_INTERVAL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOW_THRESHOLD:    low_threshold_reg    <= cfg_data[11:0];
                REG_HYSTERESIS:       hysteresis_reg       <= cfg_data[11:0];
                REG_CONTROL_INTERVAL: control_interval_reg <= cfg_data;
                REG_LOG_INTERVAL:     log_interval_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Single pass: one CRC step, field capture, or counter update and compare
    logic               [15:0] ctrl_inc, log_inc;
    logic               [15:0] raw_word;
    logic               ctrl_fire, log_fire;
    logic signed [16:0] tc, tmin, top;
    logic [1:0]         status;

    always_comb
    begin
        crc_next           = crc_reg;
        byte_count_next    = byte_count_reg;
        raw_low_next       = raw_low_reg;
        raw_high_next      = raw_high_reg;
        res_next           = res_reg;
        temp_next          = temp_reg;
        reading_valid_next = reading_valid_reg;
        heater_state_next  = heater_state_reg;
        alert_state_next   = alert_state_reg;
        ctrl_elapsed_next  = ctrl_elapsed_reg;
        log_elapsed_next   = log_elapsed_reg;
        status             = STATUS_NONE;
        ctrl_fire          = 1'b0;
        log_fire           = 1'b0;

        ctrl_inc = (ctrl_elapsed_reg == 16'hFFFF) ? ctrl_elapsed_reg : ctrl_elapsed_reg + 16'd1;
        log_inc  = (log_elapsed_reg == 16'hFFFF) ? log_elapsed_reg : log_elapsed_reg + 16'd1;

        tc   = {temp_reg[15], temp_reg};
        tmin = {{5{low_threshold_reg[11]}}, low_threshold_reg};
        top  = tmin + {{5{hysteresis_reg[11]}}, hysteresis_reg};

        if (in_op_reg == OP_BYTE)
        begin
            crc_next = crc8_step(crc_reg, in_byte_reg);
            if (byte_count_reg == POS_RAW_LOW)
                raw_low_next = in_byte_reg;
            if (byte_count_reg == POS_RAW_HIGH)
                raw_high_next = in_byte_reg;
            if (byte_count_reg == POS_CONFIG)
                res_next = in_byte_reg[6:5];
            if (byte_count_reg != COUNT_MAX)
                byte_count_next = byte_count_reg + 4'd1;
        end
        raw_word = {raw_high_next, raw_low_next} & res_mask(res_next);

        if (in_op_reg == OP_BYTE)
        begin
            if (in_last_reg)
            begin
                if (byte_count_next == FRAME_BYTES && crc_next == 8'h00)
                begin
                    temp_next          = raw_word;
                    reading_valid_next = 1'b1;
                    status             = STATUS_ACCEPT;
                end
                else
                    status = STATUS_REJECT;
                crc_next        = 8'h00;
                byte_count_next = 4'd0;
            end
        end
        else
        begin
            ctrl_elapsed_next = ctrl_inc;
            log_elapsed_next  = log_inc;
            if (reading_valid_reg && ctrl_inc >= control_interval_reg)
            begin
                ctrl_elapsed_next = 16'd0;
                ctrl_fire         = 1'b1;
                // off wins over on
                if (tc >= top)
                    heater_state_next = 1'b0;
                else if (tc < tmin)
                    heater_state_next = 1'b1;
                alert_state_next = (tc > top);
            end
            if (log_inc >= log_interval_reg)
            begin
                log_elapsed_next = 16'd0;
                log_fire         = 1'b1;
            end
        end

        out_next.pad             = 2'b00;
        out_next.log_due         = log_fire;
        out_next.control_done    = ctrl_fire;
        out_next.reading_status  = status;
        out_next.temperature     = temp_next;
        out_next.overshoot_alert = alert_state_next;
        out_next.heat_on         = heater_state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg           <= 8'h00;
            byte_count_reg    <= 4'd0;
            raw_low_reg       <= 8'h00;
            raw_high_reg      <= 8'h00;
            res_reg           <= RES_9BIT;
            temp_reg          <= 16'h0000;
            reading_valid_reg <= 1'b0;
            heater_state_reg  <= 1'b0;
            alert_state_reg   <= 1'b0;
            ctrl_elapsed_reg  <= 16'd0;
            log_elapsed_reg   <= 16'd0;
        end
        else if (advance)
        begin
            crc_reg           <= crc_next;
            byte_count_reg    <= byte_count_next;
            raw_low_reg       <= raw_low_next;
            raw_high_reg      <= raw_high_next;
            res_reg           <= res_next;
            temp_reg          <= temp_next;
            reading_valid_reg <= reading_valid_next;
            heater_state_reg  <= heater_state_next;
            alert_state_reg   <= alert_state_next;
            ctrl_elapsed_reg  <= ctrl_elapsed_next;
            log_elapsed_reg   <= log_elapsed_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    // A frame end always restarts the CRC and byte count
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_op_reg == OP_BYTE && in_last_reg
        |=> byte_count_reg == 4'd0 && crc_reg == 8'h00)
        else $error("CRC or byte count not cleared after frame end");

    // No control decision without a stored reading
    a_ctrl_needs_reading: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ctrl_fire |-> reading_valid_reg)
        else $error("control decision made with no valid reading");

    // An accepted frame leaves a valid reading behind
    a_accept_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        advance && status == STATUS_ACCEPT |=> reading_valid_reg)
        else $error("accepted reading not marked valid");

    // Overshoot implies the heater was switched off
    a_alert_heat_off: assert property (@(posedge clk) disable iff (!rst_n)
        alert_state_reg |-> !heater_state_reg)
        else $error("heater on while overshoot alert set");

endmodule

// File: tb/sst_checker.sv
module sst_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sst_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sst_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  sst_pkg::cfg_index_t             cfg_index,
    input  logic [sst_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import sst_pkg::*;

    // shadow of the configuration
    logic signed [11:0] thr_cfg;
    logic signed [11:0] band_cfg;
    logic [15:0]        ctl_period;
    logic [15:0]        log_period;

    // shadow of the thermostat state
    logic [7:0]  crc_acc;
    logic [3:0]  nbytes;
    logic [7:0]  lo_byte;
    logic [7:0]  hi_byte;
    logic [1:0]  res_code;
    logic [15:0] held_temp;
    logic        have_reading;
    logic        heater;
    logic        alert;
    logic [15:0] ctl_count;
    logic [15:0] log_count;

    result_t pending_results[$];

    // reflected CRC-8, poly 0x8C, LSB of the byte first
    function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] din);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            fb = r[0] ^ din[k];
            r  = {1'b0, r[7:1]} ^ (fb ? 8'h8C : 8'h00);
        end
        return r;
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("heat=%b alert=%b temp=%h status=%0d ctrl=%b log=%b pad=%b",
                         r.heat_on, r.overshoot_alert, r.temperature, r.reading_status,
                         r.control_done, r.log_due, r.pad);
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic step_thermostat(input logic op, input logic [7:0] din, input logic last,
                                   output result_t r);
        logic [15:0] raw;
        logic [1:0]  st;
        logic        ctrl;
        logic        logd;
        int          tc;
        int          tmin;
        int          tmax;
        st   = STATUS_NONE;
        ctrl = 1'b0;
        logd = 1'b0;
        if (op == OP_BYTE)
        begin
            crc_acc = crc_fold(crc_acc, din);
            case (nbytes)
                POS_RAW_LOW:  lo_byte  = din;
                POS_RAW_HIGH: hi_byte  = din;
                POS_CONFIG:   res_code = din[6:5];
                default: ;
            endcase
            if (nbytes != COUNT_MAX)
                nbytes++;
            if (last)
            begin
                if (nbytes == FRAME_BYTES && crc_acc == 8'h00)
                begin
                    raw = {hi_byte, lo_byte};
                    case (res_code)
                        RES_9BIT:  raw[2:0] = 3'b000;
                        RES_10BIT: raw[1:0] = 2'b00;
                        RES_11BIT: raw[0]   = 1'b0;
                        default: ;
                    endcase
                    held_temp    = raw;
                    have_reading = 1'b1;
                    st           = STATUS_ACCEPT;
                end
                else
                    st = STATUS_REJECT;
                crc_acc = 8'h00;
                nbytes  = 4'd0;
            end
        end
        else
        begin
            if (ctl_count != 16'hFFFF)
                ctl_count++;
            if (log_count != 16'hFFFF)
                log_count++;
            if (have_reading && ctl_count >= ctl_period)
            begin
                tc   = signed'(held_temp);
                tmin = thr_cfg;
                tmax = tmin + band_cfg;
                ctl_count = 16'd0;
                ctrl = 1'b1;
                if (tc < tmin)
                    heater = 1'b1;
                if (tc >= tmax)
                    heater = 1'b0;   // off wins
                alert = (tc > tmax);
            end
            if (log_count >= log_period)
            begin
                log_count = 16'd0;
                logd = 1'b1;
            end
        end
        r = '0;
        r.heat_on         = heater;
        r.overshoot_alert = alert;
        r.temperature     = held_temp;
        r.reading_status  = st;
        r.control_done    = ctrl;
        r.log_due         = logd;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            thr_cfg      = LOW_THRESHOLD_RST;
            band_cfg     = HYSTERESIS_RST;
            ctl_period   = CONTROL_INTERVAL_RST;
            log_period   = LOG_INTERVAL_RST;
            crc_acc      = 8'h00;
            nbytes       = 4'd0;
            lo_byte      = 8'h00;
            hi_byte      = 8'h00;
            res_code     = 2'd0;
            held_temp    = 16'h0000;
            have_reading = 1'b0;
            heater       = 1'b0;
            alert        = 1'b0;
            ctl_count    = 16'd0;
            log_count    = 16'd0;
            pending_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LOW_THRESHOLD:    thr_cfg    = cfg_data[11:0];
                    REG_HYSTERESIS:       band_cfg   = cfg_data[11:0];
                    REG_CONTROL_INTERVAL: ctl_period = cfg_data;
                    REG_LOG_INTERVAL:     log_period = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                seen = result_t'(m_tdata);
                if (pending_results.size() == 0)
                    report($sformatf("result with nothing expected: %s", show(seen)));
                else
                begin
                    want = pending_results.pop_front();
                    if (seen !== want)
                        report($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                         show(want), show(seen)));
                end
            end
            if (s_tvalid && s_tready)
            begin
                step_thermostat(s_tuser, s_tdata, s_tlast, want);
                pending_results.push_back(want);
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sst_pkg::*;

    // cycles with no handshake on any channel before the run is abandoned;
    // worst legal quiet spell is a long sender gap plus a long sink stall
    localparam int STALL_LIMIT    = 3000;
    // margin after the drain before touching registers
    localparam int SETTLE_CYCLES  = 4;
    localparam int ITEMS_PER_PASS = 220;

    typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_SHORT, FRAME_LONG} frame_kind_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   s_tuser   = OP_BYTE;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = REG_LOW_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    int sent_items   = 0;
    int calm_left    = 0;   // items still to go in a stretch with no sender gaps

    // stimulus-side copy of the thresholds, used to aim readings at the band
    int thr_now  = 288;
    int band_now = 16;

    sensor_scratchpad_thermostat_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sst_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // CRC over the first n bytes of a scratchpad image; used to seal good frames
    function automatic logic [7:0] scratch_crc(input logic [7:0] sp [20], input int n);
        logic [7:0] c;
        logic [7:0] b;
        c = 8'h00;
        for (int i = 0; i < n; i++)
        begin
            b = sp[i];
            for (int k = 0; k < 8; k++)
            begin
                if (c[0] ^ b[0])
                    c = (c >> 1) ^ 8'h8C;
                else
                    c = c >> 1;
                b = b >> 1;
            end
        end
        return c;
    endfunction

    // one item on the slave stream; valid stays high across back-to-back items
    task automatic send_item(input logic op, input logic [7:0] din, input logic last);
        int gap;
        gap = (calm_left > 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= din;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sent_items++;
        if (calm_left > 0)
            calm_left--;
    endtask

    // data and last ride along with a tick but must be ignored
    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_frame(input frame_kind_t kind, input logic [15:0] temp,
                              input logic [1:0] res);
        logic [7:0] sp [20];
        int         len;
        int         i;
        sp[0] = temp[7:0];
        sp[1] = temp[15:8];
        for (i = 2; i < 20; i++)
            sp[i] = 8'($urandom);
        sp[4][6:5] = res;
        sp[8] = scratch_crc(sp, 8);
        len = FRAME_BYTES;
        case (kind)
            FRAME_BAD_CRC:
            begin
                i = $urandom_range(0, 8);
                sp[i] = sp[i] ^ (8'd1 << $urandom_range(0, 7));
            end
            FRAME_SHORT:
                len = $urandom_range(1, 8);
            FRAME_LONG:
            begin
                len = $urandom_range(10, 20);
                // zero tail keeps the CRC clean, so only the length can reject it
                if ($urandom_range(0, 1) == 1)
                    for (i = 9; i < len; i++)
                        sp[i] = 8'h00;
            end
            default: ;
        endcase
        for (i = 0; i < len; i++)
        begin
            // a tick now and then in the middle of a read
            if ($urandom_range(0, 11) == 0)
                send_tick();
            send_item(OP_BYTE, sp[i], i == len - 1);
        end
    endtask

    // readings: rail values, values around the hysteresis band, anything at all
    function automatic logic [15:0] pick_temp();
        logic [15:0] rails [6];
        int          lo_t;
        int          hi_t;
        int          r;
        rails = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'hFFF8};
        r = $urandom_range(0, 99);
        if (r < 20)
            return rails[$urandom_range(0, 5)];
        if (r < 75)
        begin
            lo_t = ((band_now < 0) ? thr_now + band_now : thr_now) - 40;
            hi_t = ((band_now < 0) ? thr_now : thr_now + band_now) + 40;
            return 16'(lo_t + int'($urandom_range(0, hi_t - lo_t)));
        end
        return 16'($urandom);
    endfunction

    // drain the block, then write all four registers back to back
    task automatic configure(input int thr, input int band, input int ctl, input int logp);
        cfg_index_t   idx [4];
        logic [15:0]  val [4];
        idx = '{REG_LOW_THRESHOLD, REG_HYSTERESIS, REG_CONTROL_INTERVAL, REG_LOG_INTERVAL};
        val = '{16'(thr), 16'(band), 16'(ctl), 16'(logp)};
        s_tvalid <= 1'b0;
        // let the checker see the last item sent before reading the count
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        thr_now  = thr;
        band_now = band;
    endtask

    // mixed traffic: mostly sealed frames, some corrupt, short and long reads, tick bursts
    task automatic run_traffic(input int upto);
        int r;
        int n;
        while (sent_items < upto)
        begin
            if ($urandom_range(0, 19) == 0)
                calm_left = $urandom_range(30, 80);
            r = $urandom_range(0, 99);
            if (r < 50)
                send_frame(FRAME_GOOD, pick_temp(), 2'($urandom));
            else if (r < 58)
                send_frame(FRAME_BAD_CRC, pick_temp(), 2'($urandom));
            else if (r < 64)
                send_frame(FRAME_SHORT, pick_temp(), 2'($urandom));
            else if (r < 70)
                send_frame(FRAME_LONG, pick_temp(), 2'($urandom));
            else
            begin
                n = $urandom_range(1, 10);
                repeat (n) send_tick();
            end
        end
    endtask

    // sink side: ready runs of random length broken by stalls
    initial
    begin : sink
        int run;
        int gap;
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // watchdog: no handshake anywhere for too long means the block has hung
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int pass_end;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, at reset settings: ticks with stray data/last, a lone zero byte
        // marked last (clean CRC, wrong length), then rail readings at two resolutions
        send_item(OP_TICK, 8'hFF, 1'b1);
        send_item(OP_TICK, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_frame(FRAME_GOOD, 16'h7FFF, RES_10BIT);
        send_frame(FRAME_GOOD, 16'h8000, RES_12BIT);
        send_tick();

        pass_end = sent_items;
        pass_end += ITEMS_PER_PASS;
        run_traffic(pass_end);

        // extremes: lowest threshold with most negative band (off always wins),
        // decisions and log marks on every tick
        configure(-880, -2048, 1, 1);
        pass_end += ITEMS_PER_PASS;
        run_traffic(pass_end);

        // highest threshold and band, intervals at their top (never reached here)
        configure(2000, 2047, 65535, 65535);
        pass_end += ITEMS_PER_PASS;
        run_traffic(pass_end);

        configure(0, 0, 2, 3);
        pass_end += ITEMS_PER_PASS;
        run_traffic(pass_end);

        configure(2000, -2048, 1, 65535);
        pass_end += ITEMS_PER_PASS;
        run_traffic(pass_end);

        repeat (3)
        begin
            configure(int'($urandom_range(0, 2880)) - 880, int'($urandom_range(0, 96)) - 16,
                      $urandom_range(1, 6), $urandom_range(1, 12));
            pass_end += ITEMS_PER_PASS;
            run_traffic(pass_end);
        end

        // drain, then a short tail to catch any stray result
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
